>>> rtl/cau_pkg.sv
// Shared types and defaults for the complex arithmetic unit.
// No dependencies; every other file imports this package.
package cau_pkg;

	localparam int WORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} cau_kind_t;

	// Control flags that ride along the divider pipeline.
	typedef struct packed {
		logic neg_re;
		logic neg_im;
		logic big_re;
		logic big_im;
		logic is_div;
		logic dz;
		logic ovf;
	} cau_div_flags_t;

endpackage

>>> rtl/cau_req_if.sv
// Operand channel of the complex arithmetic unit: valid/ready plus one operand pair.
// Depends on cau_pkg for the default word width.
interface cau_req_if import cau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic signed [WORD_BITS-1:0] a_real;
	logic signed [WORD_BITS-1:0] a_imag;
	logic signed [WORD_BITS-1:0] b_real;
	logic signed [WORD_BITS-1:0] b_imag;

	modport source (output valid, kind, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, kind, a_real, a_imag, b_real, b_imag, output ready);
endinterface

>>> rtl/cau_res_if.sv
// Result channel of the complex arithmetic unit: valid/ready plus one result.
// Depends on cau_pkg for the default word width.
interface cau_res_if import cau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] res_real;
	logic signed [WORD_BITS-1:0] res_imag;
	logic                        overflow;
	logic                        div_zero;

	modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
	modport sink (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

>>> rtl/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, real and imaginary in parallel.
// Depends on cau_pkg for the flag struct and defaults.
module cau_div import cau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3*WORD_BITS+FRAC_BITS-1:0] in_n_re,
	input  logic [3*WORD_BITS+FRAC_BITS-1:0] in_n_im,
	input  logic [2*WORD_BITS-1:0]   in_den,
	input  cau_div_flags_t           in_flags,
	input  logic [2*WORD_BITS-1:0]   in_side,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [WORD_BITS-1:0]     out_q_re,
	output logic [WORD_BITS-1:0]     out_q_im,
	output cau_div_flags_t           out_flags,
	output logic [2*WORD_BITS-1:0]   out_side
);
	localparam int W  = WORD_BITS;
	localparam int PW = 2 * W;
	localparam int RW = 3 * W + FRAC_BITS;

	logic                 v_s   [W];
	logic [RW-1:0]        re_s  [W];
	logic [RW-1:0]        im_s  [W];
	logic [PW-1:0]        den_s [W];
	logic [W-1:0]         qre_s [W];
	logic [W-1:0]         qim_s [W];
	cau_div_flags_t       fl_s  [W];
	logic [PW-1:0]        sd_s  [W];
	logic                 en    [W+1];

	assign en[W]    = out_ready;
	assign in_ready = en[0];

	for (genvar j = 0; j < W; j++) begin : gen_stage
		localparam int SH = W - 1 - j;
		logic           vp;
		logic [RW-1:0]  rp_re, rp_im;
		logic [PW-1:0]  dp;
		logic [W-1:0]   qp_re, qp_im;
		cau_div_flags_t fp;
		logic [PW-1:0]  sp;
		logic [RW-1:0]  dsh;
		logic [RW:0]    t_re, t_im;

		if (j == 0) begin : gen_first
			assign vp    = in_valid;
			assign rp_re = in_n_re;
			assign rp_im = in_n_im;
			assign dp    = in_den;
			assign qp_re = '0;
			assign qp_im = '0;
			assign fp    = in_flags;
			assign sp    = in_side;
		end else begin : gen_next
			assign vp    = v_s[j-1];
			assign rp_re = re_s[j-1];
			assign rp_im = im_s[j-1];
			assign dp    = den_s[j-1];
			assign qp_re = qre_s[j-1];
			assign qp_im = qim_s[j-1];
			assign fp    = fl_s[j-1];
			assign sp    = sd_s[j-1];
		end

		// Trial subtract of the divisor aligned to this quotient bit.
		assign dsh  = RW'(dp) << SH;
		assign t_re = {1'b0, rp_re} - {1'b0, dsh};
		assign t_im = {1'b0, rp_im} - {1'b0, dsh};

		assign en[j] = !v_s[j] || en[j+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en[j]) begin
				v_s[j] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				re_s[j]  <= t_re[RW] ? rp_re : t_re[RW-1:0];
				im_s[j]  <= t_im[RW] ? rp_im : t_im[RW-1:0];
				qre_s[j] <= {qp_re[W-2:0], ~t_re[RW]};
				qim_s[j] <= {qp_im[W-2:0], ~t_im[RW]};
				den_s[j] <= dp;
				fl_s[j]  <= fp;
				sd_s[j]  <= sp;
			end
		end
	end

	assign out_valid = v_s[W-1];
	assign out_q_re  = qre_s[W-1];
	assign out_q_im  = qim_s[W-1];
	assign out_flags = fl_s[W-1];
	assign out_side  = sd_s[W-1];

endmodule

>>> rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply or divide two complex operands.
// Depends on cau_pkg, cau_req_if, cau_res_if and cau_div.

// Each item carries an operation kind and two complex operands in signed fixed
// point (WORD_BITS wide, FRAC_BITS fraction bits; Q7.8 in 16 bits by default)
// and yields exactly one result item, in order. Add and subtract saturate the
// exact sum. Multiply forms the exact products, floors after the fractional
// shift and saturates. Divide computes (a * conj(b)) / |b|^2 with the numerator
// scaled by 2^FRAC_BITS, truncated toward zero and saturated; a zero divisor
// gives zero parts with div_zero set and overflow clear. overflow flags a
// saturated part. The block is fully pipelined: a new item may enter every
// cycle while the output is not stalled, passing through three front stages for
// products, sums and scaling, WORD_BITS divider stages producing one quotient bit
// each, and the output register. All operations go through the same pipeline, so
// results leave in input order. Each stage advances when it is empty or the
// stage behind it moves, so empty slots close up while the output is stalled.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cau_req_if.sink   req,
	cau_res_if.source res
);
	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int RW = 3 * W + F;

	localparam logic signed [PW:0] WMAX_X = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [PW:0] WMIN_X = {{(PW-W+2){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W-1:0]       WMAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]       WMIN_W = {1'b1, {(W-1){1'b0}}};

	// Saturate a wide signed value to one word; top bit of the return is overflow.
	function automatic logic [W:0] sat_w(input logic signed [PW:0] x);
		logic [W:0] r;
		if (x > WMAX_X) begin
			r = {1'b1, WMAX_W};
		end else if (x < WMIN_X) begin
			r = {1'b1, WMIN_W};
		end else begin
			r = {1'b0, x[W-1:0]};
		end
		return r;
	endfunction

	// Apply sign to a quotient magnitude and saturate.
	function automatic logic [W:0] div_sat(input logic neg, input logic big,
			input logic [W-1:0] q);
		logic       ovf;
		logic [W:0] r;
		ovf = big || (neg ? (q > WMIN_W) : (q > WMAX_W));
		if (ovf) begin
			r = {1'b1, neg ? WMIN_W : WMAX_W};
		end else begin
			r = {1'b0, neg ? W'(-q) : q};
		end
		return r;
	endfunction

	// Stage handshake enables: a stage loads when empty or when it drains.
	logic en_s1, en_s2, en_s3, en_s4, div_in_ready;

	// ---------------- stage 1: products and add/subtract sum ----------------
	logic                 v_s1;
	logic [1:0]           kind_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_br2_s1, p_bi2_s1;
	logic signed [W:0]    as_re_s1, as_im_s1;

	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1  <= req.kind;
			p_rr_s1  <= PW'(req.a_real) * PW'(req.b_real);
			p_ii_s1  <= PW'(req.a_imag) * PW'(req.b_imag);
			p_ri_s1  <= PW'(req.a_real) * PW'(req.b_imag);
			p_ir_s1  <= PW'(req.a_imag) * PW'(req.b_real);
			p_br2_s1 <= PW'(req.b_real) * PW'(req.b_real);
			p_bi2_s1 <= PW'(req.b_imag) * PW'(req.b_imag);
			if (req.kind == KIND_SUB) begin
				as_re_s1 <= (W+1)'(req.a_real) - (W+1)'(req.b_real);
				as_im_s1 <= (W+1)'(req.a_imag) - (W+1)'(req.b_imag);
			end else begin
				as_re_s1 <= (W+1)'(req.a_real) + (W+1)'(req.b_real);
				as_im_s1 <= (W+1)'(req.a_imag) + (W+1)'(req.b_imag);
			end
		end
	end

	// ---------------- stage 2: cross sums and divisor magnitude ----------------
	logic               v_s2;
	logic [1:0]         kind_s2;
	logic signed [W:0]  as_re_s2, as_im_s2;
	logic signed [PW:0] mre_s2, mim_s2, nre_s2, nim_s2;
	logic [PW-1:0]      den_s2;

	assign en_s2 = !v_s2 || en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2  <= kind_s1;
			as_re_s2 <= as_re_s1;
			as_im_s2 <= as_im_s1;
			mre_s2   <= (PW+1)'(p_rr_s1) - (PW+1)'(p_ii_s1);
			mim_s2   <= (PW+1)'(p_ri_s1) + (PW+1)'(p_ir_s1);
			nre_s2   <= (PW+1)'(p_rr_s1) + (PW+1)'(p_ii_s1);
			nim_s2   <= (PW+1)'(p_ir_s1) - (PW+1)'(p_ri_s1);
			den_s2   <= $unsigned(p_br2_s1) + $unsigned(p_bi2_s1);
		end
	end

	// ---------------- stage 3: non-divide results, divide scaling ----------------
	logic               v_s3;
	logic [RW-1:0]      nre_s3, nim_s3;
	logic [PW-1:0]      den_s3;
	cau_div_flags_t     fl_s3;
	logic [PW-1:0]      side_s3;

	logic [W:0]         sat_re, sat_im;
	logic signed [PW:0] sh_re, sh_im;
	logic [PW:0]        mag_re, mag_im;
	logic [RW-1:0]      scl_re, scl_im, den_top;
	cau_div_flags_t     fl_nx;

	always_comb begin
		sh_re = mre_s2 >>> F;
		sh_im = mim_s2 >>> F;
		case (kind_s2)
			KIND_ADD, KIND_SUB: begin
				sat_re = sat_w((PW+1)'(as_re_s2));
				sat_im = sat_w((PW+1)'(as_im_s2));
			end
			KIND_MUL: begin
				sat_re = sat_w(sh_re);
				sat_im = sat_w(sh_im);
			end
			default: begin
				sat_re = '0;
				sat_im = '0;
			end
		endcase
		mag_re  = nre_s2[PW] ? (PW+1)'(-nre_s2) : nre_s2;
		mag_im  = nim_s2[PW] ? (PW+1)'(-nim_s2) : nim_s2;
		scl_re  = RW'(mag_re[PW-1:0]) << F;
		scl_im  = RW'(mag_im[PW-1:0]) << F;
		den_top = RW'(den_s2) << W;
		// Quotient of more than WORD_BITS bits always saturates; flag it here.
		fl_nx.neg_re = nre_s2[PW];
		fl_nx.neg_im = nim_s2[PW];
		fl_nx.big_re = scl_re >= den_top;
		fl_nx.big_im = scl_im >= den_top;
		fl_nx.is_div = kind_s2 == KIND_DIV;
		fl_nx.dz     = (kind_s2 == KIND_DIV) && (den_s2 == '0);
		fl_nx.ovf    = sat_re[W] || sat_im[W];
	end

	assign en_s3 = !v_s3 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			nre_s3  <= scl_re;
			nim_s3  <= scl_im;
			den_s3  <= den_s2;
			fl_s3   <= fl_nx;
			side_s3 <= {sat_re[W-1:0], sat_im[W-1:0]};
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	logic           div_out_valid;
	logic [W-1:0]   q_re, q_im;
	cau_div_flags_t div_fl;
	logic [PW-1:0]  div_side;

	cau_div #(
		.WORD_BITS (W),
		.FRAC_BITS (F)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_in_ready),
		.in_n_re   (nre_s3),
		.in_n_im   (nim_s3),
		.in_den    (den_s3),
		.in_flags  (fl_s3),
		.in_side   (side_s3),
		.out_valid (div_out_valid),
		.out_ready (en_s4),
		.out_q_re  (q_re),
		.out_q_im  (q_im),
		.out_flags (div_fl),
		.out_side  (div_side)
	);

	// ---------------- stage 4: sign, saturate, select, output register ----------------
	logic         v_s4;
	logic [W-1:0] rr_s4, ri_s4;
	logic         ovf_s4, dz_s4;

	logic [W:0]   dq_re, dq_im;
	logic [W-1:0] rr_nx, ri_nx;
	logic         ovf_nx;

	always_comb begin
		dq_re = div_sat(div_fl.neg_re, div_fl.big_re, q_re);
		dq_im = div_sat(div_fl.neg_im, div_fl.big_im, q_im);
		if (!div_fl.is_div) begin
			rr_nx  = div_side[PW-1:W];
			ri_nx  = div_side[W-1:0];
			ovf_nx = div_fl.ovf;
		end else if (div_fl.dz) begin
			rr_nx  = '0;
			ri_nx  = '0;
			ovf_nx = 1'b0;
		end else begin
			rr_nx  = dq_re[W-1:0];
			ri_nx  = dq_im[W-1:0];
			ovf_nx = dq_re[W] || dq_im[W];
		end
	end

	assign en_s4 = !v_s4 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rr_s4  <= rr_nx;
			ri_s4  <= ri_nx;
			ovf_s4 <= ovf_nx;
			dz_s4  <= div_fl.dz;
		end
	end

	assign res.valid    = v_s4;
	assign res.res_real = rr_s4;
	assign res.res_imag = ri_s4;
	assign res.overflow = ovf_s4;
	assign res.div_zero = dz_s4;

endmodule

>>> bench/complex_arithmetic_unit_tb.sv
// Self-checking bench for the complex arithmetic unit: directed table, then random items.
// Depends on cau_pkg, cau_req_if, cau_res_if and the complex_arithmetic_unit RTL.
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int WB = WORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = WB + 4;
	localparam int N_RANDOM = 1150;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [WB-1:0] word_t;

	typedef struct {
		cau_kind_t kind;
		word_t ar, ai, br, bi;
	} operands_t;

	typedef struct {
		word_t re, im;
		logic ovf, dz;
	} cplx_result_t;

	// One directed row: operands plus, optionally, a typed-in answer.
	typedef struct {
		operands_t op;
		bit fixed;
		cplx_result_t want;
	} vector_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycle_count = 0;
	int mismatch_count = 0;
	bit stim_done = 1'b0;
	bit idle_off = 1'b0;
	bit hold_sink = 1'b0;

	cplx_result_t expected_results[$];

	cau_req_if #(.WORD_BITS(WB)) req ();
	cau_res_if #(.WORD_BITS(WB)) res ();

	complex_arithmetic_unit #(.WORD_BITS(WB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Saturate a wide exact value into a word; flag when clipped.
	function automatic word_t clip(input logic signed [127:0] v, inout logic ovf);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (WB - 1)) - 1;
		lo = -(128'sd1 <<< (WB - 1));
		if (v > hi) begin
			ovf = 1'b1;
			return hi[WB-1:0];
		end
		if (v < lo) begin
			ovf = 1'b1;
			return lo[WB-1:0];
		end
		return v[WB-1:0];
	endfunction

	// Floor of v / 2^FB: arithmetic shift rounds toward minus infinity.
	function automatic logic signed [127:0] floor_frac(input logic signed [127:0] v);
		return v >>> FB;
	endfunction

	// Truncated (num * 2^FB) / den; SystemVerilog signed division truncates toward zero.
	function automatic logic signed [127:0] trunc_quot(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] scaled;
		scaled = num <<< FB;
		return scaled / den;
	endfunction

	// Compute the complex result one item should produce.
	function automatic cplx_result_t complex_result(input operands_t op);
		cplx_result_t r;
		logic signed [127:0] ar, ai, br, bi, den;
		ar = op.ar;
		ai = op.ai;
		br = op.br;
		bi = op.bi;
		r.ovf = 1'b0;
		r.dz = 1'b0;
		r.re = '0;
		r.im = '0;
		case (op.kind)
			KIND_ADD: begin
				r.re = clip(ar + br, r.ovf);
				r.im = clip(ai + bi, r.ovf);
			end
			KIND_SUB: begin
				r.re = clip(ar - br, r.ovf);
				r.im = clip(ai - bi, r.ovf);
			end
			KIND_MUL: begin
				r.re = clip(floor_frac(ar * br - ai * bi), r.ovf);
				r.im = clip(floor_frac(ar * bi + ai * br), r.ovf);
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					r.re = clip(trunc_quot(ar * br + ai * bi, den), r.ovf);
					r.im = clip(trunc_quot(ai * br - ar * bi, den), r.ovf);
				end
			end
		endcase
		return r;
	endfunction

	function automatic vector_row_t row(input cau_kind_t k, input int ar, input int ai,
			input int br, input int bi, input bit fixed = 0, input int re = 0,
			input int im = 0, input bit ovf = 0, input bit dz = 0);
		vector_row_t v;
		v.op.kind = k;
		v.op.ar = word_t'(ar);
		v.op.ai = word_t'(ai);
		v.op.br = word_t'(br);
		v.op.bi = word_t'(bi);
		v.fixed = fixed;
		v.want.re = word_t'(re);
		v.want.im = word_t'(im);
		v.want.ovf = ovf;
		v.want.dz = dz;
		return v;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
			0: return word_t'(32767);
			1: return word_t'(-32768);
			2: return '0;
			3: return word_t'($urandom_range(0, 1024)) - word_t'(512);
			4: return word_t'($urandom_range(0, 7)) - word_t'(4);
			default: return word_t'($urandom);
		endcase
	endfunction

	// Idle the sender with odds of 36 in 100 per try, except in the no-idle stretch.
	function automatic bit take_gap();
		return !idle_off && ($urandom_range(0, 99) < 36);
	endfunction

	// Offer one item, hold it until accepted, record what it should yield.
	task automatic send_item(input operands_t op, input bit fixed, input cplx_result_t want);
		while (take_gap()) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= op.kind;
		req.a_real <= op.ar;
		req.a_imag <= op.ai;
		req.b_real <= op.br;
		req.b_imag <= op.bi;
		do @(posedge clk); while (!req.ready);
		expected_results.push_back(fixed ? want : complex_result(op));
		@(negedge clk);
	endtask

	// Sink readiness: random idling, plus a long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n)
			res.ready <= 1'b0;
		else if (hold_sink)
			res.ready <= 1'b0;
		else
			res.ready <= idle_off || ($urandom_range(0, 99) >= 36);
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		cplx_result_t e;
		if (arst_n && res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result re=%0d im=%0d", res.res_real, res.res_imag);
			end else begin
				e = expected_results.pop_front();
				if (res.res_real !== e.re || res.res_imag !== e.im ||
						res.overflow !== e.ovf || res.div_zero !== e.dz) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want re=%0d im=%0d ovf=%b dz=%b, got re=%0d im=%0d ovf=%b dz=%b",
							e.re, e.im, e.ovf, e.dz, res.res_real, res.res_imag,
							res.overflow, res.div_zero);
				end
			end
		end
	end

	// Long receiver hold-off while the sender keeps offering items.
	initial begin
		int held;
		wait (stim_done == 1'b0 && cycle_count > 400);
		@(negedge clk);
		hold_sink = 1'b1;
		for (held = 0; held < 3 * LATENCY + 20; held++) @(negedge clk);
		hold_sink = 1'b0;
	end

	initial begin
		vector_row_t table_rows[$];
		operands_t op;
		cplx_result_t none;
		int i, waited;
		none = '{default: '0};
		req.valid = 1'b0;
		req.kind = '0;
		req.a_real = '0;
		req.a_imag = '0;
		req.b_real = '0;
		req.b_imag = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extremes, every operation, saturation and the zero divisor.
		table_rows.push_back(row(KIND_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		table_rows.push_back(row(KIND_ADD, 32767, 32767, 1, 1, 1, 32767, 32767, 1, 0));
		table_rows.push_back(row(KIND_ADD, -32768, -32768, -1, -1, 1, -32768, -32768, 1, 0));
		table_rows.push_back(row(KIND_ADD, 32767, -32768, -32768, 32767, 1, -1, -1, 0, 0));
		table_rows.push_back(row(KIND_SUB, -32768, 32767, 1, -1, 1, -32768, 32767, 1, 0));
		table_rows.push_back(row(KIND_SUB, 100, -200, 100, -200, 1, 0, 0, 0, 0));
		table_rows.push_back(row(KIND_SUB, 0, 0, -32768, 32767, 1, 32767, -32767, 1, 0));
		table_rows.push_back(row(KIND_MUL, 256, 0, 256, 0, 1, 256, 0, 0, 0));
		table_rows.push_back(row(KIND_MUL, -1, 0, 1, 0, 1, -1, 0, 0, 0));
		table_rows.push_back(row(KIND_MUL, -32768, -32768, -32768, -32768));
		table_rows.push_back(row(KIND_MUL, 32767, 32767, 32767, -32768));
		table_rows.push_back(row(KIND_MUL, 0, 256, 0, 256, 1, -256, 0, 0, 0));
		table_rows.push_back(row(KIND_DIV, 1234, -77, 0, 0, 1, 0, 0, 0, 1));
		table_rows.push_back(row(KIND_DIV, 0, 0, 0, 0, 1, 0, 0, 0, 1));
		table_rows.push_back(row(KIND_DIV, 256, 0, 256, 0, 1, 256, 0, 0, 0));
		table_rows.push_back(row(KIND_DIV, 32767, 32767, 1, 0, 1, 32767, 32767, 1, 0));
		table_rows.push_back(row(KIND_DIV, -32768, 32767, 0, 1));
		table_rows.push_back(row(KIND_DIV, -1, 0, 512, 0, 1, 0, 0, 0, 0));
		table_rows.push_back(row(KIND_DIV, -32768, -32768, -32768, -32768));
		table_rows.push_back(row(KIND_DIV, 32767, -32768, 32767, 32767));
		table_rows.push_back(row(KIND_DIV, 5, -3, -1, 1));
		foreach (table_rows[j])
			send_item(table_rows[j].op, table_rows[j].fixed, table_rows[j].want);

		for (i = 0; i < N_RANDOM; i++) begin
			idle_off = (i >= 300 && i < 450);
			op.kind = cau_kind_t'($urandom_range(0, 3));
			op.ar = rand_word();
			op.ai = rand_word();
			op.br = ($urandom_range(0, 15) == 0) ? word_t'(0) : rand_word();
			op.bi = ($urandom_range(0, 15) == 0) ? word_t'(0) : rand_word();
			send_item(op, 1'b0, none);
		end
		req.valid <= 1'b0;
		idle_off = 1'b0;
		stim_done = 1'b1;

		// Drain, then let the pipeline settle.
		waited = 0;
		while (expected_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
rtl/cau_pkg.sv
rtl/cau_req_if.sv
rtl/cau_res_if.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit.sv
bench/complex_arithmetic_unit_tb.sv
